@@ hdl/rcst_pkg.sv @@
// Shared types and constants for the remote start toggle with link timeout.
`default_nettype none

package rcst_pkg;

	localparam int CHANNEL_BITS = 11;
	localparam int TIME_BITS    = 32;
	localparam int TIMEOUT_BITS = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DATA_BITS = TIMEOUT_BITS;

	localparam logic [CHANNEL_BITS-1:0] CENTER_RST  = CHANNEL_BITS'(1024);
	localparam logic [CHANNEL_BITS-1:0] PRESS_RST   = CHANNEL_BITS'(180);
	localparam logic [CHANNEL_BITS-1:0] RELEASE_RST = CHANNEL_BITS'(100);
	localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = TIMEOUT_BITS'(120);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CENTER  = 3'd0,
		CFG_PRESS   = 3'd1,
		CFG_RELEASE = 3'd2,
		CFG_TIMEOUT = 3'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                    kind;
		logic [CHANNEL_BITS-1:0] channel_value;
		logic                    receiver_ok;
		logic [TIME_BITS-1:0]    now_ms;
	} in_item_t;

	typedef struct packed {
		logic                    connected;
		logic                    start_enabled;
		logic [CHANNEL_BITS-1:0] held_channel;
	} out_item_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] center_value;
		logic [CHANNEL_BITS-1:0] press_threshold;
		logic [CHANNEL_BITS-1:0] release_threshold;
		logic [TIMEOUT_BITS-1:0] link_timeout_ms;
	} cfg_t;

endpackage

`default_nettype wire

@@ hdl/rcst_core.sv @@
// Link state, stored frame and press hysteresis; updates once per stepped item.
`default_nettype none

module rcst_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire rcst_pkg::in_item_t item,
	input  wire rcst_pkg::cfg_t    cfg,
	output rcst_pkg::out_item_t    result
);
	import rcst_pkg::*;

	logic [CHANNEL_BITS-1:0] channel_q;
	logic [TIME_BITS-1:0]    last_time_q;
	logic                    alive_q;
	logic                    request_q;
	logic                    latched_q;

	logic [CHANNEL_BITS-1:0] ch_d;
	logic [TIME_BITS-1:0]    time_d;
	logic [TIME_BITS-1:0]    elapsed;
	logic                    alive_pre;
	logic                    alive_d;
	logic [CHANNEL_BITS-1:0] dev;
	logic                    request_d;
	logic                    latched_d;

	always_comb begin
		ch_d      = item.kind ? item.channel_value : channel_q;
		time_d    = item.kind ? item.now_ms : last_time_q;
		alive_pre = item.kind ? item.receiver_ok : alive_q;
		// wrapping difference; an earlier timestamp reads as a long gap
		elapsed   = item.now_ms - time_d;
		alive_d   = alive_pre &&
			!(elapsed > {{(TIME_BITS-TIMEOUT_BITS){1'b0}}, cfg.link_timeout_ms});
		dev = (ch_d >= cfg.center_value) ? (ch_d - cfg.center_value)
			: (cfg.center_value - ch_d);

		request_d = request_q;
		latched_d = latched_q;
		if (!alive_d) begin
			request_d = 1'b0;
			latched_d = 1'b0;
		end else if (latched_q) begin
			if (dev < cfg.release_threshold)
				latched_d = 1'b0;
		end else if (dev > cfg.press_threshold) begin
			latched_d = 1'b1;
			request_d = !request_q;
		end

		result.connected     = alive_d;
		result.start_enabled = request_d;
		result.held_channel  = ch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_q   <= CENTER_RST;
			last_time_q <= '0;
			alive_q     <= 1'b0;
			request_q   <= 1'b0;
			latched_q   <= 1'b0;
		end else if (step) begin
			channel_q   <= ch_d;
			last_time_q <= time_d;
			alive_q     <= alive_d;
			request_q   <= request_d;
			latched_q   <= latched_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/rc_start_toggle_with_link_timeout.sv @@
// Remote start toggle with link failsafe timeout: top level.
//
// Input channel (in_valid/in_ready/in_data): one transaction per service call,
// carrying a frame flag, channel value, receiver-ok bit and a ms timestamp.
// Output channel (out_valid/out_ready/out_data): one transaction per input,
// giving link state, start permission and the held channel value, in order.
// Config port (cfg_we/cfg_index/cfg_data): single-cycle writes, no read-back;
// indexes past the timeout register are ignored. Write only while idle.
// Each input is held in the input register, loaded at the accepting edge, and
// its result in the result register, loaded when the state update steps.
// Throughput: one transaction per cycle while the receiver does not stall, set
// by the combinational state update between the two registers.
// Receiver stall: the result register holds, the input register fills, and
// in_ready drops only when both are occupied.
// Reset: config returns to center 1024, press 180, release 100, timeout 120;
// link down, start request and press latch cleared, held channel at center.
`default_nettype none

module rc_start_toggle_with_link_timeout (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire rcst_pkg::in_item_t                 in_data,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output rcst_pkg::out_item_t                     out_data,
	input  wire logic                               cfg_we,
	input  wire logic [rcst_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [rcst_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import rcst_pkg::*;

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;
	out_item_t result;
	logic      advance;
	logic      step;

	assign advance   = !out_valid_q || out_ready;
	assign step      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_value      <= CENTER_RST;
			cfg_q.press_threshold   <= PRESS_RST;
			cfg_q.release_threshold <= RELEASE_RST;
			cfg_q.link_timeout_ms   <= TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CENTER:  cfg_q.center_value      <= cfg_data[CHANNEL_BITS-1:0];
				CFG_PRESS:   cfg_q.press_threshold   <= cfg_data[CHANNEL_BITS-1:0];
				CFG_RELEASE: cfg_q.release_threshold <= cfg_data[CHANNEL_BITS-1:0];
				CFG_TIMEOUT: cfg_q.link_timeout_ms   <= cfg_data[TIMEOUT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
		if (step)
			out_q <= result;
	end

	rcst_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	a_start_needs_link: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.start_enabled || out_q.connected))
		else $error("start enabled while link is down");

	a_bad_frame_drops_link: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.kind && !item_s1.receiver_ok) |=> !out_q.connected)
		else $error("frame without receiver ok left link up");

	a_frame_holds_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.kind) |=> (out_q.held_channel == $past(item_s1.channel_value)))
		else $error("held channel does not match last frame");

	a_s1_holds_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("input register lost an item during stall");

endmodule

`default_nettype wire

@@ verif/rc_start_toggle_with_link_timeout_test.sv @@
// Self-checking testbench for the remote start toggle with link timeout.
module rc_start_toggle_with_link_timeout_test;

	import rcst_pkg::*;

	localparam int QUIET_LIMIT = 1000;
	localparam logic CALL_ONLY = 1'b0;
	localparam logic CALL_FRAME = 1'b1;
	// an index past the last register, writes there must be dropped
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 3'd7;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	rc_start_toggle_with_link_timeout uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor copy of the registers and state
	logic [CHANNEL_BITS-1:0] set_center = CENTER_RST;
	logic [CHANNEL_BITS-1:0] set_press = PRESS_RST;
	logic [CHANNEL_BITS-1:0] set_release = RELEASE_RST;
	logic [TIMEOUT_BITS-1:0] set_timeout = TIMEOUT_RST;
	logic [CHANNEL_BITS-1:0] held_value = CENTER_RST;
	logic [TIME_BITS-1:0] frame_time = '0;
	logic link_up = 1'b0;
	logic start_req = 1'b0;
	logic press_held = 1'b0;

	out_item_t pending_results[$];
	out_item_t want;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	logic [TIME_BITS-1:0] clock_ms;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic predict_service_call(input in_item_t call, output out_item_t res);
		logic [TIME_BITS-1:0] elapsed;
		logic [CHANNEL_BITS-1:0] dev;
		if (call.kind == CALL_FRAME) begin
			held_value = call.channel_value;
			frame_time = call.now_ms;
			link_up = call.receiver_ok;
		end
		elapsed = call.now_ms - frame_time;
		if (link_up && elapsed > {16'd0, set_timeout})
			link_up = 1'b0;
		if (!link_up) begin
			start_req = 1'b0;
			press_held = 1'b0;
		end else begin
			dev = (held_value >= set_center) ? held_value - set_center : set_center - held_value;
			if (press_held) begin
				if (dev < set_release)
					press_held = 1'b0;
			end else if (dev > set_press) begin
				press_held = 1'b1;
				start_req = !start_req;
			end
		end
		res.connected = link_up;
		res.start_enabled = start_req;
		res.held_channel = held_value;
	endtask

	function automatic in_item_t make_call(input logic kind, input logic [CHANNEL_BITS-1:0] ch,
			input logic ok, input logic [TIME_BITS-1:0] t);
		in_item_t call;
		call.kind = kind;
		call.channel_value = ch;
		call.receiver_ok = ok;
		call.now_ms = t;
		return call;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned exp_v,
			input int unsigned got_v);
		$display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
		mismatch_count++;
	endtask

	task automatic send_call(input in_item_t call);
		out_item_t res;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= call;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_service_call(call, res);
		pending_results.push_back(res);
	endtask

	// drain everything in flight, then let the pipeline idle before going on
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			CFG_CENTER: set_center = data[CHANNEL_BITS-1:0];
			CFG_PRESS: set_press = data[CHANNEL_BITS-1:0];
			CFG_RELEASE: set_release = data[CHANNEL_BITS-1:0];
			CFG_TIMEOUT: set_timeout = data;
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [CHANNEL_BITS-1:0] c, p, r,
			input logic [TIMEOUT_BITS-1:0] t);
		logic [31:0] junk;
		settle();
		junk = $urandom();
		// unused upper data bits carry junk; the 11-bit registers must ignore it
		write_cfg_reg(CFG_CENTER, {junk[4:0], c});
		write_cfg_reg(CFG_PRESS, {junk[9:5], p});
		write_cfg_reg(CFG_RELEASE, {junk[14:10], r});
		write_cfg_reg(CFG_TIMEOUT, t);
		write_cfg_reg(CFG_SPARE, junk[31:16]);
		cfg_we <= 1'b0;
	endtask

	// channel value aimed below release, between thresholds, or beyond press
	function automatic logic [CHANNEL_BITS-1:0] aim_channel();
		int d;
		int c;
		case ($urandom_range(0, 2))
			0: d = $urandom_range(0, set_release);
			1: d = $urandom_range(set_release, set_press);
			default: d = set_press + $urandom_range(1, 400);
		endcase
		c = $urandom_range(0, 1) ? int'(set_center) + d : int'(set_center) - d;
		if (c < 0)
			c = 0;
		if (c > 2047)
			c = 2047;
		return CHANNEL_BITS'(c);
	endfunction

	task automatic run_session(input int n_calls);
		in_item_t call;
		int roll;
		for (int k = 0; k < n_calls; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				clock_ms += $urandom_range(0, set_timeout / 2 + 1);
				call = make_call(CALL_FRAME, aim_channel(), 1'b1, clock_ms);
			end else if (roll < 82) begin
				clock_ms += $urandom_range(0, set_timeout / 2 + 1);
				call = make_call(CALL_ONLY, 11'($urandom), 1'($urandom), clock_ms);
			end else if (roll < 88) begin
				// land right on or just past the timeout
				clock_ms += set_timeout + $urandom_range(0, 1);
				call = make_call(CALL_ONLY, 11'($urandom), 1'($urandom), clock_ms);
			end else if (roll < 93) begin
				clock_ms += $urandom_range(0, 3);
				call = make_call(CALL_FRAME, aim_channel(), 1'b0, clock_ms);
			end else begin
				call = in_item_t'({$urandom, $urandom});
				clock_ms = call.now_ms;
			end
			send_call(call);
		end
	endtask

	task automatic test_reset_state();
		idle_pct = 30;
		stall_pct = 10;
		send_call(make_call(CALL_ONLY, 11'h7ff, 1'b1, 32'd0));
		send_call(make_call(CALL_FRAME, 11'd1024, 1'b1, 32'd10));
		send_call(make_call(CALL_FRAME, 11'd1204, 1'b1, 32'd20));
		send_call(make_call(CALL_FRAME, 11'd1205, 1'b1, 32'd30));
		send_call(make_call(CALL_FRAME, 11'd2047, 1'b1, 32'd40));
		send_call(make_call(CALL_FRAME, 11'd1124, 1'b1, 32'd50));
		send_call(make_call(CALL_FRAME, 11'd1123, 1'b1, 32'd60));
		send_call(make_call(CALL_FRAME, 11'd0, 1'b1, 32'd70));
		send_call(make_call(CALL_FRAME, 11'd1024, 1'b1, 32'd80));
		// elapsed equal to the timeout keeps the link, one more drops it
		send_call(make_call(CALL_ONLY, 11'd0, 1'b0, 32'd200));
		send_call(make_call(CALL_ONLY, 11'd0, 1'b0, 32'd201));
		send_call(make_call(CALL_FRAME, 11'd2047, 1'b0, 32'hffff_fff0));
		send_call(make_call(CALL_FRAME, 11'd900, 1'b1, 32'hffff_ffff));
		send_call(make_call(CALL_ONLY, 11'h7ff, 1'b1, 32'd5));
		// timestamp behind the last frame reads as a huge gap
		send_call(make_call(CALL_ONLY, 11'h7ff, 1'b1, 32'hffff_fff0));
		send_call(make_call(CALL_FRAME, 11'd1300, 1'b1, 32'd100));
		send_call(make_call(CALL_FRAME, 11'd1300, 1'b0, 32'd101));
	endtask

	task automatic test_register_extremes();
		program_regs(11'd0, 11'd0, 11'd0, 16'd0);
		send_call(make_call(CALL_FRAME, 11'd0, 1'b1, 32'd1000));
		send_call(make_call(CALL_FRAME, 11'd1, 1'b1, 32'd1000));
		send_call(make_call(CALL_ONLY, 11'd0, 1'b0, 32'd1000));
		send_call(make_call(CALL_ONLY, 11'd0, 1'b0, 32'd1001));
		program_regs(11'd2047, 11'd2047, 11'd2047, 16'hffff);
		send_call(make_call(CALL_FRAME, 11'd0, 1'b1, 32'd0));
		send_call(make_call(CALL_ONLY, 11'd0, 1'b0, 32'd65535));
		send_call(make_call(CALL_ONLY, 11'd0, 1'b0, 32'd65536));
		// release above press: latch sets and clears on alternate frames, start toggles every other frame
		program_regs(11'd1024, 11'd100, 11'd300, 16'd1000);
		send_call(make_call(CALL_FRAME, 11'd1224, 1'b1, 32'd10));
		send_call(make_call(CALL_FRAME, 11'd1224, 1'b1, 32'd11));
		send_call(make_call(CALL_FRAME, 11'd1224, 1'b1, 32'd12));
	endtask

	task automatic test_random_sessions();
		logic [CHANNEL_BITS-1:0] p;
		for (int phase = 0; phase < 5; phase++) begin
			p = CHANNEL_BITS'($urandom_range(50, 600));
			case (phase)
				0: program_regs(11'($urandom), p, 11'($urandom_range(0, p)),
					16'($urandom_range(20, 150)));
				1: program_regs(11'd0, p, 11'($urandom_range(0, p)), 16'hffff);
				2: program_regs(11'd2047, p, 11'($urandom_range(0, p)), 16'd0);
				3: program_regs(11'($urandom), 11'($urandom), 11'($urandom), 16'($urandom));
				default: program_regs(11'($urandom), p, 11'($urandom_range(p, 2047)),
					16'($urandom_range(1, 300)));
			endcase
			idle_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(5, 40);
			stall_pct = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(3, 25);
			clock_ms = $urandom();
			run_session(85);
		end
	endtask

	task automatic test_steady_stream();
		program_regs(11'($urandom_range(700, 1300)), 11'd200, 11'd80, 16'd60);
		idle_pct = 0;
		stall_pct = 0;
		clock_ms = $urandom();
		run_session(100);
	endtask

	// receiver side stalls
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with no call pending", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (out_data.connected !== want.connected)
					report_mismatch("connected", 32'(want.connected),
						32'(out_data.connected));
				if (out_data.start_enabled !== want.start_enabled)
					report_mismatch("start_enabled", 32'(want.start_enabled),
						32'(out_data.start_enabled));
				if (out_data.held_channel !== want.held_channel)
					report_mismatch("held_channel", 32'(want.held_channel),
						32'(out_data.held_channel));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_register_extremes();
		test_random_sessions();
		test_steady_stream();
		settle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
